// File: design/sts_pkg.sv
// Shared types, token kind codes, keyword table and byte classifiers of the token scanner.
package sts_pkg;

  typedef enum logic [4:0] {
    KIND_INTERFACE, KIND_STRUCT, KIND_VOID, KIND_INT32,
    KIND_VAR, KIND_IF, KIND_ELSE, KIND_RETURN,
    KIND_IDENT, KIND_NUMBER, KIND_STRING,
    KIND_LBRACE, KIND_RBRACE, KIND_LPAREN, KIND_RPAREN,
    KIND_SEMI, KIND_COMMA, KIND_DOT, KIND_STAR,
    KIND_ASSIGN, KIND_EQEQ, KIND_NOTEQ, KIND_LESS, KIND_GREATER,
    KIND_ARROW, KIND_UNKNOWN, KIND_EOF
  } token_kind_t;

  localparam int KW_COUNT   = 8;
  localparam int KW_MAX_LEN = 9;

  // Keyword text, last character in the low byte; order matches the kind codes.
  localparam logic [8*KW_MAX_LEN-1:0] KW_STR [KW_COUNT] = '{
    "interface", "struct", "void", "int32", "var", "if", "else", "return"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd9, 4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd6
  };

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } token_t;

  // Up to two tokens produced by one accepted byte, first in stream order.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Single-byte punctuation; anything else maps to unknown.
  function automatic token_kind_t punct_kind(input logic [7:0] b);
    token_kind_t k;
    unique case (b)
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3B:   k = KIND_SEMI;
      8'h2C:   k = KIND_COMMA;
      8'h2E:   k = KIND_DOT;
      8'h2A:   k = KIND_STAR;
      8'h3C:   k = KIND_LESS;
      8'h3E:   k = KIND_GREATER;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// File: design/sts_channels.sv
// Valid/ready channel interfaces for source bytes and emitted tokens.
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       source_end;
  modport source (output valid, byte_value, source_end, input ready);
  modport sink (input valid, byte_value, source_end, output ready);
endinterface

interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;
  modport source (output valid, token_kind, token_start, token_length, line_number,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_start, token_length, line_number,
                last_of_run, output ready);
endinterface

// File: design/source_token_scanner_core.sv
// Token scanner top: one source byte per transfer in, tokens (kind, start, length, line) out.
// Latency: a token is written to the result queue at the edge that accepts the byte closing it
//   and is offered on out_ch in the next cycle if no earlier token waits in the queue ahead of it.
// Throughput: one byte per cycle while the four-entry queue has room for two tokens; a byte
//   closing two tokens costs two output transfers, so the output port sets the long-run rate.
// Reset (rst_n low, synchronous): scan mode idle, position 0, line 1, queue empty.
module source_token_scanner_core
  import sts_pkg::*;
#(
  parameter int OFFSET_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  sts_in_if.sink     in_ch,
  sts_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_EQUAL, MODE_BANG, MODE_DASH
  } scan_mode_t;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  // Scanner state
  scan_mode_t  mode_r, mode_nxt;
  pos_t        pos_r, pos_nxt;
  pos_t        start_r, start_nxt;
  logic [15:0] line_r, line_nxt;
  logic        too_long_r, too_long_nxt;
  logic [7:0]  kw_buf_r [KW_MAX_LEN];

  // Keyword buffer write port
  logic        kw_we;
  logic [3:0]  kw_idx;

  logic        room;
  logic        in_fire;
  logic [7:0]  b;
  logic        is_end;
  pos_t        lex_len;
  pos_t        pos_inc;
  logic [15:0] line_inc;
  logic        ident_char;
  logic        pending;
  logic        continue_tok;
  logic        flush_go;
  token_kind_t ident_kind;
  token_t      tok_a, tok_b;
  logic        tok_b_v;
  logic [OFFSET_BITS:0] str_start;
  logic [OFFSET_BITS:0] str_len;
  push_t       push;

  // Clamp an offset or length to the 16-bit output fields.
  function automatic logic [15:0] sat16(input logic [32:0] v);
    return (v > 33'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;
  assign b           = in_ch.byte_value;
  assign is_end      = in_ch.source_end;

  // The token start never passes the position, so this never wraps.
  assign lex_len  = pos_r - start_r;
  // Position and line both stick at their top value.
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + pos_t'(1);
  assign line_inc = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;

  assign ident_char = is_alpha(b) || is_digit(b) || (b == CH_UNDER);

  assign pending = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER) ||
                   (mode_r == MODE_EQUAL) || (mode_r == MODE_BANG) || (mode_r == MODE_DASH);

  // Byte extends the token held in the current mode.
  assign continue_tok = ((mode_r == MODE_IDENT) && ident_char) ||
                        ((mode_r == MODE_NUMBER) && is_digit(b)) ||
                        (((mode_r == MODE_EQUAL) || (mode_r == MODE_BANG)) &&
                         (b == CH_EQUAL)) ||
                        ((mode_r == MODE_DASH) && (b == CH_GREATER));

  // Held token closes: end marker, or a byte that cannot extend it.
  assign flush_go = pending && (is_end || !continue_tok);

  // Keyword match: compare the buffered identifier against all keywords at once.
  always_comb begin
    logic hit;
    ident_kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = !too_long_r && (lex_len <= pos_t'(KW_MAX_LEN)) &&
            (lex_len[3:0] == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          if (kw_buf_r[i] != KW_STR[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        ident_kind = token_kind_t'(5'(k));
      end
    end
  end

  // Token held by the mode, closed before the current byte is looked at.
  always_comb begin
    tok_a.start  = sat16(33'(start_r));
    tok_a.line   = line_r;
    tok_a.last   = !tok_b_v;
    tok_a.length = 16'd1;
    unique case (mode_r)
      MODE_IDENT: begin
        tok_a.kind   = ident_kind;
        tok_a.length = sat16(33'(lex_len));
      end
      MODE_NUMBER: begin
        tok_a.kind   = KIND_NUMBER;
        tok_a.length = sat16(33'(lex_len));
      end
      MODE_EQUAL: tok_a.kind = KIND_ASSIGN;
      default:    tok_a.kind = KIND_UNKNOWN;
    endcase
  end

  // String body runs from just after the opening quote to just before the closing one.
  assign str_start = {1'b0, start_r} + (OFFSET_BITS+1)'(1);
  assign str_len   = ({1'b0, pos_r} >= str_start) ? ({1'b0, pos_r} - str_start) : '0;

  // Next state and the token the current byte itself produces.
  always_comb begin
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    line_nxt     = line_r;
    too_long_nxt = too_long_r;
    kw_we        = 1'b0;
    kw_idx       = lex_len[3:0];
    tok_b_v      = 1'b0;
    tok_b.kind   = KIND_UNKNOWN;
    tok_b.start  = sat16(33'(pos_r));
    tok_b.length = 16'd1;
    tok_b.line   = line_r;
    tok_b.last   = 1'b1;

    if (is_end) begin
      // Flush is handled by tok_a; emit end of file and restart the source.
      tok_b_v      = 1'b1;
      tok_b.kind   = KIND_EOF;
      tok_b.length = 16'd0;
      mode_nxt     = MODE_IDLE;
      pos_nxt      = '0;
      start_nxt    = '0;
      line_nxt     = 16'd1;
      too_long_nxt = 1'b0;
    end else begin
      // Every byte advances the position once.
      pos_nxt = pos_inc;
      if (mode_r == MODE_STRING) begin
        if (b == CH_QUOTE) begin
          tok_b_v      = 1'b1;
          tok_b.kind   = KIND_STRING;
          tok_b.start  = sat16(33'(str_start));
          tok_b.length = sat16(33'(str_len));
          mode_nxt     = MODE_IDLE;
        end else if (b == CH_LF) begin
          line_nxt = line_inc;
        end
      end else if (continue_tok) begin
        if (mode_r == MODE_IDENT) begin
          // Buffer only the first nine bytes; a longer name is never a keyword.
          if (lex_len < pos_t'(KW_MAX_LEN)) begin
            kw_we = 1'b1;
          end else begin
            too_long_nxt = 1'b1;
          end
        end else if (mode_r != MODE_NUMBER) begin
          // Second byte of a two-byte operator.
          tok_b_v      = 1'b1;
          tok_b.start  = sat16(33'(start_r));
          tok_b.length = 16'd2;
          mode_nxt     = MODE_IDLE;
          unique case (mode_r)
            MODE_EQUAL: tok_b.kind = KIND_EQEQ;
            MODE_BANG:  tok_b.kind = KIND_NOTEQ;
            default:    tok_b.kind = KIND_ARROW;
          endcase
        end
      end else begin
        // Byte starts fresh: token start sits after any skipped whitespace.
        start_nxt = pos_r;
        mode_nxt  = MODE_IDLE;
        priority if ((b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR)) begin
          // skip
        end else if (b == CH_LF) begin
          line_nxt = line_inc;
        end else if (b == CH_EQUAL) begin
          mode_nxt = MODE_EQUAL;
        end else if (b == CH_BANG) begin
          mode_nxt = MODE_BANG;
        end else if (b == CH_DASH) begin
          mode_nxt = MODE_DASH;
        end else if (b == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
        end else if (is_digit(b)) begin
          mode_nxt = MODE_NUMBER;
        end else if (is_alpha(b) || (b == CH_UNDER)) begin
          mode_nxt     = MODE_IDENT;
          too_long_nxt = 1'b0;
          kw_we        = 1'b1;
          kw_idx       = 4'd0;
        end else begin
          // Single-byte punctuation or unknown byte.
          tok_b_v    = 1'b1;
          tok_b.kind = punct_kind(b);
        end
      end
    end
  end

  // Hand up to two tokens to the queue, flushed token first.
  always_comb begin
    push.count  = in_fire ? (2'(flush_go) + 2'(tok_b_v)) : 2'd0;
    push.first  = flush_go ? tok_a : tok_b;
    push.second = tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      pos_r      <= '0;
      start_r    <= '0;
      line_r     <= 16'd1;
      too_long_r <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      line_r     <= line_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  // Keyword buffer holds payload only; entries are read only after being written.
  always_ff @(posedge clk) begin
    if (in_fire && kw_we) begin
      kw_buf_r[kw_idx] <= b;
    end
  end

  sts_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  a_end_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |=> (pos_r == '0) && (line_r == 16'd1) && (mode_r == MODE_IDLE))
    else $error("end marker did not restart the scanner");

  a_line_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line count reached zero");

  a_string_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_end && (mode_r == MODE_STRING) && (b != CH_QUOTE))
      |=> (mode_r == MODE_STRING) && $stable(start_r))
    else $error("string scan left early");

  a_pair_needs_flush : assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> flush_go && tok_b_v)
    else $error("two tokens pushed without a flushed token");

endmodule

// File: design/sts_result_fifo.sv
// Four-entry token queue taking up to two tokens per cycle and draining one per transfer.
module sts_result_fifo
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        room,
  sts_out_if.source   out_ch
);

  logic [2:0] cnt_r;
  logic [1:0] wr_r;
  logic [1:0] rd_r;
  token_t     slot_r [4];
  token_t     head;
  logic       pop;

  assign pop  = out_ch.valid && out_ch.ready;
  // Room for a worst-case pair of tokens.
  assign room = (cnt_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_r + 3'(push.count) - 3'(pop);
      wr_r  <= wr_r + push.count;
      rd_r  <= rd_r + 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      slot_r[wr_r + 2'd1] <= push.second;
    end
  end

  assign head                = slot_r[rd_r];
  assign out_ch.valid        = (cnt_r != 3'd0);
  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_start  = head.start;
  assign out_ch.token_length = head.length;
  assign out_ch.line_number  = head.line;
  assign out_ch.last_of_run  = head.last;

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> cnt_r <= 3'd2)
    else $error("token queue written without room");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("token queue count out of range");

  a_drain_step : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.count == 2'd0) |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("token queue count did not follow a lone transfer");

endmodule

// File: sim/testbench.sv
// Self-checking bench for the token scanner: byte stream in, predicted token stream checked out.
module testbench
  import sts_pkg::*;
;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 710;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_EQUAL, SCAN_BANG, SCAN_DASH
  } scan_state_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eos;
  } src_item_t;

  logic clk;
  logic rst_n;

  sts_in_if  in_ch ();
  sts_out_if out_ch ();

  source_token_scanner_core #(.OFFSET_BITS(16)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  string kw_words [8] = '{"interface", "struct", "void", "int32", "var", "if", "else", "return"};
  string op_words [6] = '{"==", "!=", "->", "=", "!", "-"};
  string lead_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string punct_chars = "{}();,.*<>";

  src_item_t src_q [$];     // bytes and end markers still to be sent
  token_t    token_q [$];   // tokens predicted and not yet seen
  token_t    batch [$];     // tokens caused by the byte being predicted

  // Scanner shadow state.
  scan_state_t st_mode;
  logic [15:0] st_pos;
  logic [15:0] st_start;
  logic [15:0] st_line;
  logic [7:0]  st_word [9];
  logic        st_long;

  int errors;
  int items_sent;
  int tokens_checked;
  int sources_sent;

  src_item_t cur_item;
  int        burst_left;
  int        gap_left;
  int        rx_style;
  int        rx_cycle;
  int        rx_stall;
  int        rx_count;
  int        idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_scan();
    st_mode  = SCAN_IDLE;
    st_pos   = '0;
    st_start = '0;
    st_line  = 16'd1;
    st_long  = 1'b0;
    foreach (st_word[i]) st_word[i] = '0;
  endfunction

  // Position and line both stick at their maximum.
  function automatic void bump_pos();
    if (st_pos != 16'hFFFF) st_pos++;
  endfunction

  function automatic void bump_line();
    if (st_line != 16'hFFFF) st_line++;
  endfunction

  function automatic logic [15:0] word_len();
    return (st_pos >= st_start) ? st_pos - st_start : 16'd0;
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_lead(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
  endfunction

  function automatic void add_token(token_kind_t k, logic [15:0] start, logic [15:0] len);
    token_t t;
    t.kind   = k;
    t.start  = start;
    t.length = len;
    t.line   = st_line;
    t.last   = 1'b0;
    batch.push_back(t);
  endfunction

  // Keep the first nine bytes of an identifier; past that it can never be a keyword.
  function automatic void note_letter(logic [7:0] b);
    logic [15:0] idx;
    idx = word_len();
    if (idx < 9) st_word[idx] = b;
    else st_long = 1'b1;
  endfunction

  function automatic token_kind_t ident_class();
    logic [15:0] n;
    bit          hit;
    n = word_len();
    if (st_long || n > 9) return KIND_IDENT;
    for (int k = 0; k < 8; k++) begin
      if (kw_words[k].len() == n) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++)
          if (st_word[i] != kw_words[k][i]) hit = 1'b0;
        if (hit) return token_kind_t'(k);
      end
    end
    return KIND_IDENT;
  endfunction

  // Handle a byte seen with no token open; the lexeme starts after any whitespace.
  function automatic void start_lexeme(logic [7:0] b);
    token_kind_t k;
    bit          single;
    st_start = st_pos;
    single   = 1'b1;
    k        = KIND_UNKNOWN;
    case (b)
      CH_SPACE, CH_TAB, CH_CR: single = 1'b0;
      CH_LF: begin
        bump_line();
        single = 1'b0;
      end
      CH_EQUAL: begin
        st_mode = SCAN_EQUAL;
        single  = 1'b0;
      end
      CH_BANG: begin
        st_mode = SCAN_BANG;
        single  = 1'b0;
      end
      CH_DASH: begin
        st_mode = SCAN_DASH;
        single  = 1'b0;
      end
      CH_QUOTE: begin
        st_mode = SCAN_STRING;
        single  = 1'b0;
      end
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      ";": k = KIND_SEMI;
      ",": k = KIND_COMMA;
      ".": k = KIND_DOT;
      "*": k = KIND_STAR;
      "<": k = KIND_LESS;
      CH_GREATER: k = KIND_GREATER;
      default: begin
        if (is_num(b)) begin
          st_mode = SCAN_NUMBER;
          single  = 1'b0;
        end else if (is_lead(b)) begin
          st_mode = SCAN_IDENT;
          st_long = 1'b0;
          note_letter(b);
          single  = 1'b0;
        end
      end
    endcase
    if (single) add_token(k, st_start, 16'd1);
    bump_pos();
  endfunction

  // Close whatever token is open, dropping an unfinished string, without consuming a byte.
  function automatic void close_pending();
    case (st_mode)
      SCAN_IDENT:  add_token(ident_class(), st_start, word_len());
      SCAN_NUMBER: add_token(KIND_NUMBER, st_start, word_len());
      SCAN_EQUAL:  add_token(KIND_ASSIGN, st_start, 16'd1);
      SCAN_BANG, SCAN_DASH: add_token(KIND_UNKNOWN, st_start, 16'd1);
      default: ;
    endcase
    st_mode = SCAN_IDLE;
  endfunction

  // Advance the shadow scanner by one accepted item and queue the tokens it yields.
  function automatic void predict_item(src_item_t it);
    logic [16:0] str_first;
    logic [15:0] str_len;
    logic [7:0]  b;
    logic [7:0]  pair_byte;
    token_kind_t pair_kind;
    b = it.value;
    batch.delete();
    if (it.eos) begin
      close_pending();
      add_token(KIND_EOF, st_pos, 16'd0);
      clear_scan();
    end else begin
      case (st_mode)
        SCAN_IDENT: begin
          if (is_lead(b) || is_num(b)) begin
            note_letter(b);
            bump_pos();
          end else begin
            close_pending();
            start_lexeme(b);
          end
        end
        SCAN_NUMBER: begin
          if (is_num(b)) begin
            bump_pos();
          end else begin
            close_pending();
            start_lexeme(b);
          end
        end
        SCAN_STRING: begin
          if (b == CH_QUOTE) begin
            // Quotes are not part of the lexeme; start may run one past the saturated position.
            str_first = {1'b0, st_start} + 17'd1;
            str_len   = ({1'b0, st_pos} >= str_first) ? st_pos - str_first[15:0] : 16'd0;
            add_token(KIND_STRING, str_first[16] ? 16'hFFFF : str_first[15:0], str_len);
            st_mode = SCAN_IDLE;
          end else if (b == CH_LF) begin
            bump_line();
          end
          bump_pos();
        end
        SCAN_EQUAL, SCAN_BANG, SCAN_DASH: begin
          pair_byte = (st_mode == SCAN_DASH) ? CH_GREATER : CH_EQUAL;
          pair_kind = (st_mode == SCAN_EQUAL) ? KIND_EQEQ :
                      (st_mode == SCAN_BANG) ? KIND_NOTEQ : KIND_ARROW;
          if (b == pair_byte) begin
            bump_pos();
            add_token(pair_kind, st_start, 16'd2);
            st_mode = SCAN_IDLE;
          end else begin
            close_pending();
            start_lexeme(b);
          end
        end
        default: start_lexeme(b);
      endcase
    end
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) token_q.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(logic [7:0] b);
    src_item_t it;
    it.value = b;
    it.eos   = 1'b0;
    src_q.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // The byte field of an end marker is don't-care; randomize it.
  task automatic add_end();
    src_item_t it;
    it.value = 8'($urandom_range(0, 255));
    it.eos   = 1'b1;
    src_q.push_back(it);
  endtask

  // Build one source from a mix of real tokens, near-keywords, separators and noise.
  task automatic add_random_source();
    string s;
    logic [7:0] b;
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 19))
        0, 1, 2: add_text(kw_words[$urandom_range(0, 7)]);
        3: begin
          add_text(kw_words[$urandom_range(0, 7)]);
          add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
        end
        4: begin
          s = kw_words[$urandom_range(0, 7)];
          add_text(s.substr(0, s.len() - 2));
        end
        5, 6: begin
          add_byte(lead_chars[$urandom_range(0, lead_chars.len() - 1)]);
          repeat ($urandom_range(0, 11))
            add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
        end
        7, 8: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)));
        9: begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 8)) begin
            b = ($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255));
            add_byte((b == CH_QUOTE) ? CH_SPACE : b);
          end
          add_byte(CH_QUOTE);
        end
        10, 11, 12: add_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        13, 14: add_text(op_words[$urandom_range(0, 5)]);
        15: add_byte(8'($urandom_range(0, 255)));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        2, 3, 4: add_byte(CH_SPACE);
        5: add_byte(CH_TAB);
        6: add_byte(CH_CR);
        7: add_byte(CH_LF);
        default: ;
      endcase
    end
    // Now and then leave a string open at the end marker.
    if ($urandom_range(0, 11) == 0) begin
      add_byte(CH_QUOTE);
      add_text("abc");
    end
    add_end();
  endtask

  // ---------------------------------------------------------------- input driver

  // Send in bursts of random length separated by random gaps; hold each item until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.byte_value <= '0;
      in_ch.source_end <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(cur_item);
        items_sent++;
        if (cur_item.eos) sources_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (src_q.size() != 0) begin
          cur_item = src_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.byte_value <= cur_item.value;
          in_ch.source_end <= cur_item.eos;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output side

  // Switch between free flow, coin-flip, one-in-four and long-stall patterns every so often.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle = 0;
      rx_stall = 0;
      rx_count = 0;
    end else begin
      if (rx_cycle == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_cycle = $urandom_range(20, 150);
      end else begin
        rx_cycle--;
      end
      rx_count++;
      case (rx_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_count % 4 == 0);
        default: begin
          if (rx_stall != 0) begin
            rx_stall--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare every token transfer against the oldest prediction.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        $error("token_kind: expected none, got %0d (start %0d, length %0d)",
               out_ch.token_kind, out_ch.token_start, out_ch.token_length);
        errors++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", want.kind, out_ch.token_kind);
        check_field("token_start", want.start, out_ch.token_start);
        check_field("token_length", want.length, out_ch.token_length);
        check_field("line_number", want.line, out_ch.line_number);
        check_field("last_of_run", want.last, out_ch.last_of_run);
        tokens_checked++;
      end
    end
  end

  // Drop out if neither channel moves for too long while work is outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (src_q.size() != 0 || in_ch.valid || token_q.size() != 0) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                 STALL_LIMIT, token_q.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int base;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.byte_value = '0;
    in_ch.source_end = 1'b0;
    out_ch.ready     = 1'b0;
    errors         = 0;
    items_sent     = 0;
    tokens_checked = 0;
    sources_sent   = 0;
    idle_cycles    = 0;
    rx_style       = 0;
    clear_scan();

    // Directed: all punctuation, pairs and their lone forms, unknown bytes.
    add_text("{}();,.*<>");
    add_end();
    add_text("a=b==c!=d->e!f-g");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_text("~@");
    add_end();
    // Every keyword, a number running into an identifier, a string over a newline.
    add_text("int32 void,struct;var(if)else{return}");
    add_end();
    add_text("interfaces interface \"s\t\n\"");
    add_byte(CH_CR);
    add_text("\n42_x =");
    add_end();
    // Pending bang, pending dash, open string at the end marker, empty source.
    add_text("9!");
    add_end();
    add_text("-");
    add_end();
    add_text("\"open\n");
    add_end();
    add_end();

    // Mixed tokens across several lines ending in a keyword held at the end marker.
    add_text("ab \"c\nd\" 7 ==;\nelse");
    add_end();

    base = src_q.size();
    while (src_q.size() - base < RANDOM_ITEMS) add_random_source();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last transfer and every predicted token; sample away from the edge.
    do @(negedge clk);
    while (src_q.size() != 0 || in_ch.valid || token_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d items in %0d sources, checked %0d tokens", items_sent, sources_sent,
             tokens_checked);
    $display("covered keywords, near-keywords, punctuation, operator pairs, strings, numbers");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
